// File: design/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_defines: assertion macros for the console writer
// Clocked on clk, disabled while rst_n is low, in the scope of the user.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// cons must hold whenever ante holds
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// bad must never hold
`define TCW_ASSERT_NEVER(label, bad, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

// File: design/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, command codes, operation classes and the queue entry.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CODE_W  = 8;
    localparam int POS_W   = 11;
    localparam int VALUE_W = 16;
    localparam int ATTR_W  = 8;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // entries between front and back; a power of two
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'h0a;
    localparam logic [CODE_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0]  RESET_ATTR   = 8'h0f;
    localparam logic [VALUE_W-1:0] RESET_BLANK  = {RESET_ATTR, BLANK_CODE};

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_SET,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  pos;
    } queue_item_t;

endpackage
`default_nettype wire

// File: design/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_if: command and result channels of the text console writer
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] position;

    modport source (output valid, output cmd, output char_code, output position,
                    input ready);
    modport sink   (input valid, input cmd, input char_code, input position,
                    output ready);
endinterface

interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor;
    logic [15:0] cell_value;
    logic        scrolled;

    modport source (output valid, output cursor, output cell_value, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor, input cell_value, input scrolled,
                    output ready);
endinterface
`default_nettype wire

// File: design/tcw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_queue: short FIFO of classified commands
// Decouples the command front from the cell-store back.
// ----------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_item_t push_item,
    output logic        full,
    input  logic        pop,
    output queue_item_t pop_item,
    output logic        not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    queue_item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// File: design/tcw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front: command intake and classification
// Turns each command beat into an operation class and queues it.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
(
    input  logic        sweeping,
    input  logic        q_full,
    output logic        q_push,
    output queue_item_t q_item,
    tcw_in_if.sink      in_ch
);

    op_t op;

    always_comb
    begin
        unique case (in_ch.cmd)
            CMD_PUT:
            begin
                if (in_ch.char_code == '0)
                    op = OP_NOP;
                else if (in_ch.char_code == NEWLINE_CODE)
                    op = OP_NEWLINE;
                else
                    op = OP_CHAR;
            end
            CMD_SET:   op = OP_SET;
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = OP_READ;
        endcase
    end

    // no intake while the store is being blanked after reset
    assign in_ch.ready = !q_full && !sweeping;
    assign q_push      = in_ch.valid && in_ch.ready;
    assign q_item      = '{op: op, code: in_ch.char_code, pos: in_ch.position};

endmodule
`default_nettype wire

// File: design/tcw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back: cell store, cursor and command sequencer
// Executes queued operations: writes, newline, scroll copy, clear, read.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ATTR_W-1:0] attr,
    input  logic              q_valid,
    input  queue_item_t       q_item,
    output logic              q_pop,
    output logic              sweeping,
    tcw_out_if.source         out_ch
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CUR_MAX = (CELLS > (1 << POS_W) - 1) ? CELLS : (1 << POS_W) - 1;
    localparam int CUR_W   = $clog2(CUR_MAX + 1);

    // row number by reciprocal: estimate is exact or one low
    localparam int SHIFT   = CUR_W + $clog2(COLUMNS);
    localparam int RECIP_W = CUR_W + 1;
    localparam int PROD_W  = CUR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / COLUMNS);

    localparam logic [ADDR_W-1:0] A_COLS     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] A_LAST     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] A_LAST_ROW = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] A_COPY_END = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [CUR_W-1:0]  C_CELLS    = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0]  C_COLS     = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0]  C_LAST_ROW = CUR_W'(CELLS - COLUMNS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHAR,
        S_NL_MUL,
        S_NL_BASE,
        S_NL_FIX,
        S_SCR_RD,
        S_SCR_WR,
        S_BLANK,
        S_CLEAR,
        S_READ,
        S_READ_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [CUR_W-1:0]     cursor_reg, cursor_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    queue_item_t          item_reg, item_next;
    logic                 scrolled_reg, scrolled_next;
    logic                 post_reg, post_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [CUR_W-1:0]     base_reg, base_next;
    logic                 out_valid_reg, out_valid_next;
    logic [POS_W-1:0]     out_cursor_reg, out_cursor_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_scrolled_reg, out_scrolled_next;

    logic [VALUE_W-1:0]   mem [CELLS];
    logic [VALUE_W-1:0]   rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    logic                 emit;
    logic [VALUE_W-1:0]   emit_value;
    logic [VALUE_W-1:0]   blank;
    logic [CUR_W-1:0]     cursor_inc;
    logic [CUR_W-1:0]     nl_diff;
    logic [CUR_W-1:0]     nl_sum;

    assign blank      = {attr, BLANK_CODE};
    assign cursor_inc = cursor_reg + CUR_W'(1);
    assign nl_diff    = cursor_reg - base_reg;
    assign nl_sum     = base_reg + C_COLS + ((nl_diff >= C_COLS) ? C_COLS : '0);

    assign sweeping          = (state_reg == S_INIT);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cursor     = out_cursor_reg;
    assign out_ch.cell_value = out_value_reg;
    assign out_ch.scrolled   = out_scrolled_reg;

    always_comb
    begin
        state_next        = state_reg;
        cursor_next       = cursor_reg;
        idx_next          = idx_reg;
        item_next         = item_reg;
        scrolled_next     = scrolled_reg;
        post_next         = post_reg;
        prod_next         = prod_reg;
        base_next         = base_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_cursor_next   = out_cursor_reg;
        out_value_next    = out_value_reg;
        out_scrolled_next = out_scrolled_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = blank;
        mem_re            = 1'b0;
        mem_raddr         = idx_reg + A_COLS;
        emit              = 1'b0;
        emit_value        = '0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = RESET_BLANK;
                if (idx_reg == A_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                // start only when the result slot is free by the time we finish
                if (q_valid && (!out_valid_reg || out_ch.ready))
                begin
                    q_pop         = 1'b1;
                    item_next     = q_item;
                    scrolled_next = 1'b0;
                    post_next     = 1'b0;
                    idx_next      = '0;
                    unique case (q_item.op) inside
                        OP_NOP:
                            emit = 1'b1;
                        OP_SET:
                        begin
                            cursor_next = CUR_W'(q_item.pos);
                            emit        = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (CUR_W'(q_item.pos) < C_CELLS)
                                state_next = S_READ;
                            else
                                emit = 1'b1;
                        end
                        OP_CLEAR:
                            state_next = S_CLEAR;
                        OP_CHAR, OP_NEWLINE:
                        begin
                            // cursor parked past the end: scroll first
                            if (cursor_reg >= C_CELLS)
                            begin
                                scrolled_next = 1'b1;
                                state_next    = S_SCR_RD;
                            end
                            else if (q_item.op == OP_CHAR)
                                state_next = S_CHAR;
                            else
                                state_next = S_NL_MUL;
                        end
                    endcase
                end
            end
            S_CHAR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = ADDR_W'(cursor_reg);
                mem_wdata   = {attr, item_reg.code};
                cursor_next = cursor_inc;
                if (cursor_inc >= C_CELLS)
                begin
                    post_next     = 1'b1;
                    scrolled_next = 1'b1;
                    idx_next      = '0;
                    state_next    = S_SCR_RD;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NL_MUL:
            begin
                prod_next  = PROD_W'(cursor_reg) * PROD_W'(RECIP);
                state_next = S_NL_BASE;
            end
            S_NL_BASE:
            begin
                base_next  = CUR_W'(prod_reg[PROD_W-1:SHIFT] * COLUMNS);
                state_next = S_NL_FIX;
            end
            S_NL_FIX:
            begin
                cursor_next = nl_sum;
                if (nl_sum >= C_CELLS)
                begin
                    post_next     = 1'b1;
                    scrolled_next = 1'b1;
                    idx_next      = '0;
                    state_next    = S_SCR_RD;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCR_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if (idx_reg == A_COPY_END)
                begin
                    idx_next   = A_LAST_ROW;
                    state_next = S_BLANK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCR_RD;
                end
            end
            S_BLANK:
            begin
                mem_we = 1'b1;
                if (idx_reg == A_LAST)
                begin
                    cursor_next = C_LAST_ROW;
                    idx_next    = '0;
                    if (post_reg)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (item_reg.op == OP_CHAR)
                        state_next = S_CHAR;
                    else
                        state_next = S_NL_MUL;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == A_LAST)
                begin
                    idx_next   = '0;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(item_reg.pos);
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                emit       = 1'b1;
                emit_value = rdata_reg;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_cursor_next   = cursor_next[POS_W-1:0];
            out_value_next    = emit_value;
            out_scrolled_next = scrolled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            cursor_reg       <= '0;
            idx_reg          <= '0;
            item_reg         <= '{op: OP_NOP, code: '0, pos: '0};
            scrolled_reg     <= 1'b0;
            post_reg         <= 1'b0;
            prod_reg         <= '0;
            base_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_cursor_reg   <= '0;
            out_value_reg    <= '0;
            out_scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cursor_reg       <= cursor_next;
            idx_reg          <= idx_next;
            item_reg         <= item_next;
            scrolled_reg     <= scrolled_next;
            post_reg         <= post_next;
            prod_reg         <= prod_next;
            base_reg         <= base_next;
            out_valid_reg    <= out_valid_next;
            out_cursor_reg   <= out_cursor_next;
            out_value_reg    <= out_value_next;
            out_scrolled_reg <= out_scrolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule
`default_nettype wire

// File: design/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"
// ----------------------------------------------------------------------------
// text_console_writer: character-cell console writer
// Cell store of attribute/code pairs with cursor, newline, scroll and clear.
//
//   channel   dir   beat fields
//   in_ch     in    cmd, char_code, position
//   out_ch    out   cursor, cell_value, scrolled
//   cfg       in    cfg_we, cfg_wdata (text attribute)
//
// Commands run one at a time in the sequencer; clear writes every cell, and each scroll
// copies the rows up and blanks the last row.
// After reset the store is blanked with in_ch.ready low.
// A two-beat queue keeps taking commands while the sequencer or out_ch stalls.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata,
    tcw_in_if.sink            in_ch,
    tcw_out_if.source         out_ch
);

    logic [ATTR_W-1:0] attr_reg;
    logic              sweeping;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    queue_item_t       q_push_item;
    queue_item_t       q_pop_item;
    logic              scroll_with_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= RESET_ATTR;
        else if (cfg_we)
            attr_reg <= cfg_wdata;
    end

    tcw_front u_front (
        .sweeping (sweeping),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item),
        .in_ch    (in_ch)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .not_empty (q_valid)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .attr     (attr_reg),
        .q_valid  (q_valid),
        .q_item   (q_pop_item),
        .q_pop    (q_pop),
        .sweeping (sweeping),
        .out_ch   (out_ch)
    );

    assign scroll_with_data = out_ch.valid && out_ch.scrolled && (out_ch.cell_value != '0);

    `TCW_ASSERT_IMPLY(a_no_beat_in_sweep, q_push, !sweeping, "beat taken during store blanking")
    `TCW_ASSERT_NEVER(a_push_full, q_push && q_full, "queue push while full")
    `TCW_ASSERT_IMPLY(a_pop_nonempty, q_pop, q_valid, "queue pop while empty")
    `TCW_ASSERT_NEVER(a_scroll_no_read, scroll_with_data, "scrolling result carries cell data")

endmodule
`default_nettype wire
